/* hw/rtl/nrhc_pkg.sv */
// Shared types and constants for the NTRIP caster response header check.
package nrhc_pkg;

    localparam int          COUNT_BITS_DEFAULT   = 17;
    localparam logic [15:0] HEADER_LIMIT_RESET   = 16'd16384;

    localparam logic [2:0]  VERDICT_PENDING      = 3'd0;
    localparam logic [2:0]  VERDICT_ACCEPTED     = 3'd1;
    localparam logic [2:0]  VERDICT_TOO_LARGE    = 3'd2;
    localparam logic [2:0]  VERDICT_SOURCE_TABLE = 3'd3;
    localparam logic [2:0]  VERDICT_REJECTED     = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first_of_reply;
    } nrhc_in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [16:0] body_start;
        logic        is_body;
    } nrhc_out_t;

endpackage

/* hw/rtl/ntrip_response_header_check.sv */
// Top level: per-byte verdict on an NTRIP caster reply header.
//
// Usage:
//   Reply bytes enter on the in channel (in_valid/in_stall/in_data), one per
//   transfer; set first_of_reply on byte zero of each reply to restart.
//   Every input byte yields exactly one result transfer on the out channel
//   (out_valid/out_stall/out_data) carrying verdict, body_start and is_body.
//   The cfg channel writes header_limit; cfg_ready is always high. Write it
//   only while no byte is in flight.
// Timing:
//   An input register feeds the matchers; combinational logic writes the
//   result register. out_valid rises once the byte has moved from the
//   input register into the result register, which a stalled output delays.
//   Throughput is one byte per cycle unless the output stalls.
// Reset:
//   rst_n clears both pipeline registers, all parse state and sets
//   header_limit to 16384.
// Backpressure:
//   With out_stall high the result register holds; the input register still
//   takes one more byte, then in_stall rises until the result is taken.
module ntrip_response_header_check
    import nrhc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  nrhc_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output nrhc_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_LINE,
        PH_AFTER,
        PH_HEAD,
        PH_DONE
    } phase_t;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_RTCM = 8'hD3;

    localparam logic [3:0] ICY_LEN   = 4'd7;
    localparam logic [2:0] HTTP_LEN  = 3'd5;
    localparam logic [3:0] TABLE_LEN = 4'd11;
    localparam logic [3:0] FAIL4     = 4'hF;
    localparam logic [2:0] FAIL3     = 3'h7;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b >= 8'h09 && b <= 8'h0D) || b == 8'h20 || b == 8'h85 || b == 8'hA0;
    endfunction

    function automatic logic [7:0] icy_char(input logic [3:0] i);
        case (i)
            4'd0:    icy_char = "I";
            4'd1:    icy_char = "C";
            4'd2:    icy_char = "Y";
            4'd3:    icy_char = " ";
            4'd4:    icy_char = "2";
            4'd5:    icy_char = "0";
            4'd6:    icy_char = "0";
            default: icy_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] http_char(input logic [2:0] i);
        case (i)
            3'd0:    http_char = "H";
            3'd1:    http_char = "T";
            3'd2:    http_char = "T";
            3'd3:    http_char = "P";
            3'd4:    http_char = "/";
            default: http_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] table_char(input logic [3:0] i);
        case (i)
            4'd0:    table_char = "S";
            4'd1:    table_char = "O";
            4'd2:    table_char = "U";
            4'd3:    table_char = "R";
            4'd4:    table_char = "C";
            4'd5:    table_char = "E";
            4'd6:    table_char = "T";
            4'd7:    table_char = "A";
            4'd8:    table_char = "B";
            4'd9:    table_char = "L";
            4'd10:   table_char = "E";
            default: table_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] code_char(input logic [1:0] i);
        case (i)
            2'd0:    code_char = " ";
            2'd1:    code_char = "2";
            2'd2:    code_char = "0";
            2'd3:    code_char = "0";
            default: code_char = 8'h00;
        endcase
    endfunction

    // pipeline
    logic                  in_valid_reg;
    nrhc_in_t              in_item_reg;
    logic                  out_valid_reg;
    nrhc_out_t             out_item_reg;
    logic [15:0]           header_limit_reg;

    // parse state
    logic [COUNT_BITS-1:0] byte_count_reg;
    phase_t                phase_reg;
    logic                  prev_cr_reg;
    logic [3:0]            icy_reg;
    logic [2:0]            http_reg;
    logic [3:0]            table_reg;
    logic [2:0]            code_prog_reg;
    logic                  code_seen_reg;
    logic [1:0]            blank_reg;
    logic [2:0]            verdict_reg;
    logic [COUNT_BITS-1:0] body_start_reg;

    // state after optional restart
    logic [COUNT_BITS-1:0] byte_count_cur;
    phase_t                phase_cur;
    logic                  prev_cr_cur;
    logic [3:0]            icy_cur;
    logic [2:0]            http_cur;
    logic [3:0]            table_cur;
    logic [2:0]            code_prog_cur;
    logic                  code_seen_cur;
    logic [1:0]            blank_cur;
    logic [2:0]            verdict_cur;
    logic [COUNT_BITS-1:0] body_start_cur;

    logic [COUNT_BITS-1:0] byte_count_next;
    phase_t                phase_next;
    logic                  prev_cr_next;
    logic [3:0]            icy_next;
    logic [2:0]            http_next;
    logic [3:0]            table_next;
    logic [2:0]            code_prog_next;
    logic                  code_seen_next;
    logic [1:0]            blank_next;
    logic [2:0]            verdict_next;
    logic [COUNT_BITS-1:0] body_start_next;
    nrhc_out_t             out_item_next;

    logic                  advance;
    logic [7:0]            b;
    logic [7:0]            u;
    logic                  over_limit;
    logic                  feed;
    logic                  is_body;
    logic [2:0]            code_tmp;
    logic [31:0]           body_start_wide;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    assign b = in_item_reg.rx_byte;
    assign u = (b >= "a" && b <= "z") ? b - 8'd32 : b;

    always_comb
    begin
        if (in_item_reg.first_of_reply)
        begin
            byte_count_cur = '0;
            phase_cur      = PH_SKIP;
            prev_cr_cur    = 1'b0;
            icy_cur        = '0;
            http_cur       = '0;
            table_cur      = '0;
            code_prog_cur  = '0;
            code_seen_cur  = 1'b0;
            blank_cur      = '0;
            verdict_cur    = VERDICT_PENDING;
            body_start_cur = '0;
        end
        else
        begin
            byte_count_cur = byte_count_reg;
            phase_cur      = phase_reg;
            prev_cr_cur    = prev_cr_reg;
            icy_cur        = icy_reg;
            http_cur       = http_reg;
            table_cur      = table_reg;
            code_prog_cur  = code_prog_reg;
            code_seen_cur  = code_seen_reg;
            blank_cur      = blank_reg;
            verdict_cur    = verdict_reg;
            body_start_cur = body_start_reg;
        end
    end

    always_comb
    begin
        byte_count_next = (byte_count_cur == '1) ? byte_count_cur
                                                 : byte_count_cur + 1'b1;
        over_limit      = 32'(byte_count_next) > 32'(header_limit_reg);
        phase_next      = phase_cur;
        prev_cr_next    = prev_cr_cur;
        icy_next        = icy_cur;
        http_next       = http_cur;
        table_next      = table_cur;
        code_prog_next  = code_prog_cur;
        code_seen_next  = code_seen_cur;
        blank_next      = blank_cur;
        verdict_next    = verdict_cur;
        body_start_next = body_start_cur;
        feed            = 1'b0;
        is_body         = 1'b0;
        code_tmp        = '0;

        case (phase_cur)
            PH_SKIP, PH_LINE:
            begin
                if (prev_cr_cur && b == CH_LF)
                begin
                    if (icy_cur == ICY_LEN || (http_cur == HTTP_LEN && code_seen_cur))
                    begin
                        phase_next = PH_AFTER;
                        blank_next = 2'd2;
                    end
                    else
                    begin
                        verdict_next = (table_cur == TABLE_LEN) ? VERDICT_SOURCE_TABLE
                                                                : VERDICT_REJECTED;
                        phase_next   = PH_DONE;
                    end
                end
                else
                begin
                    if (phase_cur == PH_LINE)
                    begin
                        feed = 1'b1;
                    end
                    else if (!is_space(b))
                    begin
                        feed       = 1'b1;
                        phase_next = PH_LINE;
                    end
                    if (over_limit)
                    begin
                        verdict_next = VERDICT_TOO_LARGE;
                        phase_next   = PH_DONE;
                    end
                end
                prev_cr_next = (b == CH_CR);
            end
            PH_AFTER, PH_HEAD:
            begin
                if (phase_cur == PH_AFTER && b == CH_RTCM)
                begin
                    verdict_next    = VERDICT_ACCEPTED;
                    body_start_next = byte_count_cur;
                    is_body         = 1'b1;
                    phase_next      = PH_DONE;
                end
                else
                begin
                    phase_next = PH_HEAD;
                    case (blank_cur)
                        2'd0, 2'd2:
                        begin
                            blank_next = (b == CH_CR) ? blank_cur + 2'd1 : 2'd0;
                        end
                        default:
                        begin
                            if (b == CH_LF)
                            begin
                                blank_next = blank_cur + 2'd1;
                                if (blank_cur == 2'd3)
                                begin
                                    verdict_next    = VERDICT_ACCEPTED;
                                    body_start_next = byte_count_next;
                                    phase_next      = PH_DONE;
                                end
                            end
                            else
                            begin
                                blank_next = (b == CH_CR) ? 2'd1 : 2'd0;
                            end
                        end
                    endcase
                    if (phase_next == PH_HEAD && over_limit)
                    begin
                        verdict_next = VERDICT_TOO_LARGE;
                        phase_next   = PH_DONE;
                    end
                end
            end
            PH_DONE:
            begin
                is_body = (verdict_cur == VERDICT_ACCEPTED);
            end
            default:
            begin
                is_body = 1'b0;
            end
        endcase

        // first-line prefix matchers
        if (feed)
        begin
            if (icy_cur < ICY_LEN)
            begin
                icy_next = (u == icy_char(icy_cur)) ? icy_cur + 4'd1 : FAIL4;
            end
            if (http_cur < HTTP_LEN)
            begin
                http_next = (u == http_char(http_cur)) ? http_cur + 3'd1 : FAIL3;
            end
            if (table_cur < TABLE_LEN)
            begin
                table_next = (u == table_char(table_cur)) ? table_cur + 4'd1 : FAIL4;
            end
            if (!code_seen_cur)
            begin
                if (b == code_char(code_prog_cur[1:0]))
                begin
                    code_tmp = code_prog_cur + 3'd1;
                end
                else
                begin
                    code_tmp = (b == CH_SP) ? 3'd1 : 3'd0;
                end
                if (code_tmp >= 3'd4)
                begin
                    code_seen_next = 1'b1;
                    code_prog_next = '0;
                end
                else
                begin
                    code_prog_next = code_tmp;
                end
            end
        end

        body_start_wide          = 32'(body_start_next);
        out_item_next.verdict    = verdict_next;
        out_item_next.body_start = (verdict_next == VERDICT_ACCEPTED) ? body_start_wide[16:0]
                                                                      : 17'd0;
        out_item_next.is_body    = is_body;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            in_item_reg      <= '0;
            out_valid_reg    <= 1'b0;
            out_item_reg     <= '0;
            header_limit_reg <= HEADER_LIMIT_RESET;
            byte_count_reg   <= '0;
            phase_reg        <= PH_SKIP;
            prev_cr_reg      <= 1'b0;
            icy_reg          <= '0;
            http_reg         <= '0;
            table_reg        <= '0;
            code_prog_reg    <= '0;
            code_seen_reg    <= 1'b0;
            blank_reg        <= '0;
            verdict_reg      <= VERDICT_PENDING;
            body_start_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                header_limit_reg <= cfg_data;
            end

            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
                in_item_reg  <= in_data;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                out_item_reg   <= out_item_next;
                byte_count_reg <= byte_count_next;
                phase_reg      <= phase_next;
                prev_cr_reg    <= prev_cr_next;
                icy_reg        <= icy_next;
                http_reg       <= http_next;
                table_reg      <= table_next;
                code_prog_reg  <= code_prog_next;
                code_seen_reg  <= code_seen_next;
                blank_reg      <= blank_next;
                verdict_reg    <= verdict_next;
                body_start_reg <= body_start_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/nrhc_checker.sv */
// Port-level assertions for the NTRIP response header check, with bind.
module nrhc_checker
    import nrhc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input nrhc_out_t out_data
);

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.verdict == VERDICT_PENDING
                   || out_data.verdict == VERDICT_ACCEPTED
                   || out_data.verdict == VERDICT_TOO_LARGE
                   || out_data.verdict == VERDICT_SOURCE_TABLE
                   || out_data.verdict == VERDICT_REJECTED)
        else $error("verdict code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.verdict != VERDICT_ACCEPTED |-> out_data.body_start == 17'd0)
        else $error("body_start set without accepted verdict");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_body |-> out_data.verdict == VERDICT_ACCEPTED)
        else $error("body byte flagged without accepted verdict");

endmodule

bind ntrip_response_header_check nrhc_checker u_nrhc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
